[rtl/haf_pkg.sv]
// ----------------------------------------------------------------------------
// Haar feature evaluator package
// Shared types, codes, the diagonal slot table and the control program ROM.
// ----------------------------------------------------------------------------
package haf_pkg;

	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_COLS_DEF   = 64;
	localparam int ENTRY_BITS_DEF = 24;

	// Coordinates and spans stay below 512, so ten bits always suffice.
	localparam int CRD_W  = 10;
	// Compare width that holds both a 7-bit register and the largest dimension.
	localparam int CMP_W  = 11;
	localparam int DIM_W  = 7;
	localparam int FEAT_W = 32;
	localparam int PC_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_NEXT    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		FT_EDGE = 2'd0,
		FT_LINE = 2'd1,
		FT_DIAG = 2'd2
	} ftype_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FEATURE_TYPE    = 3'd0,
		REG_SPLIT_AXIS      = 3'd1,
		REG_MAX_CELL_HEIGHT = 3'd2,
		REG_MAX_CELL_WIDTH  = 3'd3,
		REG_IMAGE_HEIGHT    = 3'd4,
		REG_IMAGE_WIDTH     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       feature_type;
		logic             split_axis;
		logic [DIM_W-1:0] max_cell_height;
		logic [DIM_W-1:0] max_cell_width;
		logic [DIM_W-1:0] image_height;
		logic [DIM_W-1:0] image_width;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_DISPATCH = 3'd0,
		OP_NOP      = 3'd1,
		OP_SEEK     = 3'd2,
		OP_SUM_INIT = 3'd3,
		OP_SUM_TERM = 3'd4,
		OP_EMIT     = 3'd5,
		OP_EXHAUST  = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		CND_NONE       = 3'd0,
		CND_CMD_NEXT   = 3'd1,
		CND_FINISHED   = 3'd2,
		CND_SEEK_BUSY  = 3'd3,
		CND_SEEK_FAIL  = 3'd4,
		CND_TERMS_LEFT = 3'd5,
		CND_OUT_BUSY   = 3'd6
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            ret;
	} uword_t;

	typedef struct packed {
		logic cmd_next;
		logic finished;
		logic seek_busy;
		logic seek_fail;
		logic terms_left;
		logic out_busy;
	} status_t;

	localparam logic [PC_W-1:0] ST_DISPATCH  = 4'd0;
	localparam logic [PC_W-1:0] ST_CHECK     = 4'd1;
	localparam logic [PC_W-1:0] ST_SEEK      = 4'd2;
	localparam logic [PC_W-1:0] ST_SEEK_CHK  = 4'd3;
	localparam logic [PC_W-1:0] ST_SUM_INIT  = 4'd4;
	localparam logic [PC_W-1:0] ST_SUM       = 4'd5;
	localparam logic [PC_W-1:0] ST_DRAIN0    = 4'd6;
	localparam logic [PC_W-1:0] ST_DRAIN1    = 4'd7;
	localparam logic [PC_W-1:0] ST_SEEK_NEXT = 4'd8;
	localparam logic [PC_W-1:0] ST_EMIT      = 4'd9;
	localparam logic [PC_W-1:0] ST_EXHAUST   = 4'd10;

	// Unit slots (row, col) of the four diagonal rectangles.
	localparam logic DIAG_SLOT [0:7] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

	function automatic uword_t mk(input op_t op, input cond_t cond,
			input logic [PC_W-1:0] target, input logic ret);
		uword_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		w.ret    = ret;
		return w;
	endfunction

	// Control program. A step jumps to its target when its condition holds,
	// otherwise it moves on, or returns to dispatch when ret is set.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			ST_DISPATCH:  w = mk(OP_DISPATCH, CND_CMD_NEXT, ST_CHECK, 1'b1);
			ST_CHECK:     w = mk(OP_NOP, CND_FINISHED, ST_EXHAUST, 1'b0);
			ST_SEEK:      w = mk(OP_SEEK, CND_SEEK_BUSY, ST_SEEK, 1'b0);
			ST_SEEK_CHK:  w = mk(OP_NOP, CND_SEEK_FAIL, ST_EXHAUST, 1'b0);
			ST_SUM_INIT:  w = mk(OP_SUM_INIT, CND_NONE, ST_DISPATCH, 1'b0);
			ST_SUM:       w = mk(OP_SUM_TERM, CND_TERMS_LEFT, ST_SUM, 1'b0);
			ST_DRAIN0:    w = mk(OP_NOP, CND_NONE, ST_DISPATCH, 1'b0);
			ST_DRAIN1:    w = mk(OP_NOP, CND_NONE, ST_DISPATCH, 1'b0);
			ST_SEEK_NEXT: w = mk(OP_SEEK, CND_SEEK_BUSY, ST_SEEK_NEXT, 1'b0);
			ST_EMIT:      w = mk(OP_EMIT, CND_OUT_BUSY, ST_EMIT, 1'b1);
			ST_EXHAUST:   w = mk(OP_EXHAUST, CND_OUT_BUSY, ST_EXHAUST, 1'b1);
			default:      w = mk(OP_NOP, CND_NONE, ST_DISPATCH, 1'b1);
		endcase
		return w;
	endfunction

endpackage

[rtl/haf_sequencer.sv]
// ----------------------------------------------------------------------------
// Haar feature evaluator sequencer
// Step counter over the control ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module haf_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  haf_pkg::status_t status,
	output haf_pkg::uword_t  uw
);

	logic [haf_pkg::PC_W-1:0] pc_q;
	logic [haf_pkg::PC_W-1:0] pc_next;
	logic                     take;

	assign uw = haf_pkg::ucode(pc_q);

	always_comb begin
		unique case (uw.cond)
			haf_pkg::CND_CMD_NEXT:   take = status.cmd_next;
			haf_pkg::CND_FINISHED:   take = status.finished;
			haf_pkg::CND_SEEK_BUSY:  take = status.seek_busy;
			haf_pkg::CND_SEEK_FAIL:  take = status.seek_fail;
			haf_pkg::CND_TERMS_LEFT: take = status.terms_left;
			haf_pkg::CND_OUT_BUSY:   take = status.out_busy;
			default:                 take = 1'b0;
		endcase
		priority if (take) begin
			pc_next = uw.target;
		end else if (uw.ret) begin
			pc_next = haf_pkg::ST_DISPATCH;
		end else begin
			pc_next = pc_q + haf_pkg::PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= haf_pkg::ST_DISPATCH;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

[rtl/haf_datapath.sv]
// ----------------------------------------------------------------------------
// Haar feature evaluator datapath
// Integral store, search registers, rectangle term pipeline, accumulator and
// result register, all driven by the current control word.
// ----------------------------------------------------------------------------
module haf_datapath #(
	parameter int MAX_ROWS   = haf_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = haf_pkg::MAX_COLS_DEF,
	parameter int ENTRY_BITS = haf_pkg::ENTRY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  haf_pkg::uword_t                    uw,
	input  haf_pkg::cfg_t                      cfg,
	input  logic                               in_accept,
	input  logic [1:0]                         in_cmd,
	input  logic [5:0]                         in_row,
	input  logic [5:0]                         in_col,
	input  logic [23:0]                        in_value,
	input  logic                               out_ready,
	output haf_pkg::status_t                   status,
	output logic                               out_valid,
	output logic signed [haf_pkg::FEAT_W-1:0]  out_value,
	output logic [5:0]                         out_row,
	output logic [5:0]                         out_col,
	output logic [haf_pkg::DIM_W-1:0]          out_height,
	output logic [haf_pkg::DIM_W-1:0]          out_width,
	output logic                               out_last,
	output logic                               out_exhausted
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = haf_pkg::CRD_W;
	localparam int MW    = haf_pkg::CMP_W;

	function automatic logic [CW-1:0] scale(input logic [1:0] f, input logic [CW-1:0] v);
		logic [CW-1:0] s;
		unique case (f)
			2'd0:    s = '0;
			2'd1:    s = v;
			2'd2:    s = v << 1;
			default: s = v + (v << 1);
		endcase
		return s;
	endfunction

	// Committed enumeration position and working copies.
	logic [CW-1:0] pos_r_q, pos_c_q, pos_h_q, pos_w_q;
	logic          finished_q;
	logic [CW-1:0] wk_r_q, wk_c_q, wk_h_q, wk_w_q;
	logic [CW-1:0] ft_r_q, ft_c_q, ft_h_q, ft_w_q;
	logic [1:0]    k_q, t_q;

	logic                     vld_s1, vld_s2;
	logic                     sub_s1, sub_s2;
	logic [CW-1:0]            row_s1, col_s1;
	logic [ENTRY_BITS-1:0]    rd_s2;
	logic [haf_pkg::FEAT_W-1:0] acc_q;

	logic [ENTRY_BITS-1:0] store_mem [DEPTH];

	logic          out_valid_q;
	logic          out_busy;

	// Effective configuration.
	logic [CW-1:0] img_h, img_w, max_h, max_w;
	logic [1:0]    fac_r, fac_c;
	logic          type_bad;

	always_comb begin
		if (cfg.image_height == '0) begin
			img_h = CW'(1);
		end else if (MW'(cfg.image_height) > MW'(MAX_ROWS)) begin
			img_h = CW'(MAX_ROWS);
		end else begin
			img_h = CW'(cfg.image_height);
		end
		if (cfg.image_width == '0) begin
			img_w = CW'(1);
		end else if (MW'(cfg.image_width) > MW'(MAX_COLS)) begin
			img_w = CW'(MAX_COLS);
		end else begin
			img_w = CW'(cfg.image_width);
		end
		max_h = (cfg.max_cell_height == '0) ? CW'(1) : CW'(cfg.max_cell_height);
		max_w = (cfg.max_cell_width == '0) ? CW'(1) : CW'(cfg.max_cell_width);
		type_bad = 1'b0;
		unique case (cfg.feature_type)
			haf_pkg::FT_EDGE: begin
				fac_r = cfg.split_axis ? 2'd1 : 2'd2;
				fac_c = cfg.split_axis ? 2'd2 : 2'd1;
			end
			haf_pkg::FT_LINE: begin
				fac_r = cfg.split_axis ? 2'd1 : 2'd3;
				fac_c = cfg.split_axis ? 2'd3 : 2'd1;
			end
			haf_pkg::FT_DIAG: begin
				fac_r = 2'd2;
				fac_c = 2'd2;
			end
			default: begin
				fac_r = 2'd1;
				fac_c = 2'd1;
				type_bad = 1'b1;
			end
		endcase
	end

	// One search step: the first failing test decides what moves.
	logic seek_fail, adv_row, adv_col, adv_h, seek_fit;

	always_comb begin
		seek_fail = type_bad || (wk_r_q >= img_h);
		adv_row   = wk_c_q >= img_w;
		adv_col   = (wk_h_q > max_h) || ((wk_r_q + scale(fac_r, wk_h_q)) > img_h);
		adv_h     = (wk_w_q > max_w) || ((wk_c_q + scale(fac_c, wk_w_q)) > img_w);
		seek_fit  = !seek_fail && !adv_row && !adv_col && !adv_h;
	end

	// Corner of the current rectangle term.
	logic [1:0]    slot_r, slot_c, last_k;
	logic [CW-1:0] t0, t1, b0, b1, t0m, t1m;
	logic [CW-1:0] term_row, term_col;
	logic          term_vld, term_neg;

	always_comb begin
		if (cfg.feature_type == haf_pkg::FT_DIAG) begin
			slot_r = {1'b0, haf_pkg::DIAG_SLOT[{k_q, 1'b0}]};
			slot_c = {1'b0, haf_pkg::DIAG_SLOT[{k_q, 1'b1}]};
		end else begin
			slot_r = cfg.split_axis ? 2'd0 : k_q;
			slot_c = cfg.split_axis ? k_q : 2'd0;
		end
		unique case (cfg.feature_type)
			haf_pkg::FT_EDGE: last_k = 2'd1;
			haf_pkg::FT_LINE: last_k = 2'd2;
			default:          last_k = 2'd3;
		endcase
		t0  = ft_r_q + scale(slot_r, ft_h_q);
		t1  = ft_c_q + scale(slot_c, ft_w_q);
		b0  = t0 + ft_h_q - CW'(1);
		b1  = t1 + ft_w_q - CW'(1);
		t0m = t0 - CW'(1);
		t1m = t1 - CW'(1);
		unique case (t_q)
			2'd0: begin
				term_row = b0;  term_col = b1;  term_vld = 1'b1;         term_neg = 1'b0;
			end
			2'd1: begin
				term_row = t0m; term_col = t1m;
				term_vld = (t0 != '0) && (t1 != '0);
				term_neg = 1'b0;
			end
			2'd2: begin
				term_row = t0m; term_col = b1;  term_vld = (t0 != '0);   term_neg = 1'b1;
			end
			default: begin
				term_row = b0;  term_col = t1m; term_vld = (t1 != '0);   term_neg = 1'b1;
			end
		endcase
	end

	// Store port: writes arrive only at dispatch; read data is used only while summing.
	logic          mem_we;
	logic [AW-1:0] waddr, raddr, mem_addr;

	assign mem_we = (uw.op == haf_pkg::OP_DISPATCH) && in_accept
		&& (in_cmd == haf_pkg::CMD_WRITE)
		&& (MW'(in_row) < MW'(MAX_ROWS)) && (MW'(in_col) < MW'(MAX_COLS));
	assign waddr    = AW'(AW'(in_row) * AW'(MAX_COLS) + AW'(in_col));
	assign raddr    = AW'(AW'(row_s1) * AW'(MAX_COLS) + AW'(col_s1));
	assign mem_addr = mem_we ? waddr : raddr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_addr] <= ENTRY_BITS'(in_value);
		end
		rd_s2 <= store_mem[mem_addr];
	end

	assign out_busy = out_valid_q && !out_ready;

	assign status.cmd_next   = in_accept && (in_cmd == haf_pkg::CMD_NEXT);
	assign status.finished   = finished_q;
	assign status.seek_busy  = !seek_fail && !seek_fit;
	assign status.seek_fail  = seek_fail;
	assign status.terms_left = !((k_q == last_k) && (t_q == 2'd3));
	assign status.out_busy   = out_busy;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_r_q     <= '0;
			pos_c_q     <= '0;
			pos_h_q     <= CW'(1);
			pos_w_q     <= CW'(1);
			finished_q  <= 1'b0;
			k_q         <= '0;
			t_q         <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (uw.op == haf_pkg::OP_SUM_TERM) && term_vld;
			vld_s2 <= vld_s1;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (uw.op)
				haf_pkg::OP_DISPATCH: begin
					if (in_accept && (in_cmd == haf_pkg::CMD_RESTART)) begin
						pos_r_q    <= '0;
						pos_c_q    <= '0;
						pos_h_q    <= CW'(1);
						pos_w_q    <= CW'(1);
						finished_q <= 1'b0;
					end
				end
				haf_pkg::OP_SUM_INIT: begin
					k_q <= '0;
					t_q <= '0;
				end
				haf_pkg::OP_SUM_TERM: begin
					t_q <= t_q + 2'd1;
					if (t_q == 2'd3) begin
						k_q <= k_q + 2'd1;
					end
				end
				haf_pkg::OP_EMIT: begin
					if (!out_busy) begin
						out_valid_q <= 1'b1;
						if (seek_fail) begin
							finished_q <= 1'b1;
						end else begin
							pos_r_q <= wk_r_q;
							pos_c_q <= wk_c_q;
							pos_h_q <= wk_h_q;
							pos_w_q <= wk_w_q;
						end
					end
				end
				haf_pkg::OP_EXHAUST: begin
					if (!out_busy) begin
						out_valid_q <= 1'b1;
						finished_q  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		row_s1 <= term_row;
		col_s1 <= term_col;
		sub_s1 <= term_neg ^ ~k_q[0];
		sub_s2 <= sub_s1;
		if (uw.op == haf_pkg::OP_SUM_INIT) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= sub_s2 ? acc_q - haf_pkg::FEAT_W'(rd_s2)
			                : acc_q + haf_pkg::FEAT_W'(rd_s2);
		end
		unique case (uw.op)
			haf_pkg::OP_DISPATCH: begin
				if (in_accept && (in_cmd == haf_pkg::CMD_NEXT)) begin
					wk_r_q <= pos_r_q;
					wk_c_q <= pos_c_q;
					wk_h_q <= pos_h_q;
					wk_w_q <= pos_w_q;
				end
			end
			haf_pkg::OP_SEEK: begin
				if (!seek_fail && !seek_fit) begin
					priority if (adv_row) begin
						wk_r_q <= wk_r_q + CW'(1);
						wk_c_q <= '0;
						wk_h_q <= CW'(1);
						wk_w_q <= CW'(1);
					end else if (adv_col) begin
						wk_c_q <= wk_c_q + CW'(1);
						wk_h_q <= CW'(1);
						wk_w_q <= CW'(1);
					end else begin
						wk_h_q <= wk_h_q + CW'(1);
						wk_w_q <= CW'(1);
					end
				end
			end
			haf_pkg::OP_SUM_INIT: begin
				ft_r_q <= wk_r_q;
				ft_c_q <= wk_c_q;
				ft_h_q <= wk_h_q;
				ft_w_q <= wk_w_q;
				wk_w_q <= wk_w_q + CW'(1);
			end
			haf_pkg::OP_EMIT: begin
				if (!out_busy) begin
					out_value     <= acc_q;
					out_row       <= ft_r_q[5:0];
					out_col       <= ft_c_q[5:0];
					out_height    <= ft_h_q[haf_pkg::DIM_W-1:0];
					out_width     <= ft_w_q[haf_pkg::DIM_W-1:0];
					out_last      <= seek_fail;
					out_exhausted <= 1'b0;
				end
			end
			haf_pkg::OP_EXHAUST: begin
				if (!out_busy) begin
					out_value     <= '0;
					out_row       <= '0;
					out_col       <= '0;
					out_height    <= '0;
					out_width     <= '0;
					out_last      <= 1'b0;
					out_exhausted <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/haar_feature_evaluator.sv]
// ----------------------------------------------------------------------------
// Haar feature evaluator
// Enumerates Haar-like features over a stored integral image and returns one
// feature value per next request.
// ----------------------------------------------------------------------------
// Write, restart and ignored requests are handled at the dispatch step. A next
// request reads the store at most once per corner of each of its n = 2, 3 or 4
// rectangles, takes one search step per skipped position or size, and may wait
// for the previous result to leave the output register. Once finished is set, an
// exhausted answer is given without a search.
// Reset clears position, cell size, finished flag and registers, not the store.
module haar_feature_evaluator #(
	parameter int MAX_ROWS   = haf_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = haf_pkg::MAX_COLS_DEF,
	parameter int ENTRY_BITS = haf_pkg::ENTRY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [39:0]                       s_tdata,   // row, col, value
	input  logic [1:0]                        s_tuser,   // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// feature_value, cell_row, cell_col, cell_height, cell_width
	output logic [63:0]                       m_tdata,
	output logic [0:0]                        m_tuser,   // exhausted
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [haf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [haf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	haf_pkg::cfg_t    cfg_q;
	haf_pkg::uword_t  uw;
	haf_pkg::status_t status;

	logic                             in_accept;
	logic signed [haf_pkg::FEAT_W-1:0] out_value;
	logic [5:0]                       out_row, out_col;
	logic [haf_pkg::DIM_W-1:0]        out_height, out_width;
	logic                             out_last, out_exhausted;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.feature_type    <= haf_pkg::FT_EDGE;
			cfg_q.split_axis      <= 1'b1;
			cfg_q.max_cell_height <= haf_pkg::DIM_W'(1);
			cfg_q.max_cell_width  <= haf_pkg::DIM_W'(1);
			cfg_q.image_height    <= haf_pkg::DIM_W'(64);
			cfg_q.image_width     <= haf_pkg::DIM_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				haf_pkg::REG_FEATURE_TYPE:    cfg_q.feature_type    <= cfg_data[1:0];
				haf_pkg::REG_SPLIT_AXIS:      cfg_q.split_axis      <= cfg_data[0];
				haf_pkg::REG_MAX_CELL_HEIGHT: cfg_q.max_cell_height <= cfg_data;
				haf_pkg::REG_MAX_CELL_WIDTH:  cfg_q.max_cell_width  <= cfg_data;
				haf_pkg::REG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data;
				haf_pkg::REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Requests are taken only at the dispatch step of the program.
	assign s_tready  = (uw.op == haf_pkg::OP_DISPATCH);
	assign in_accept = s_tvalid && s_tready;

	haf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uw     (uw)
	);

	haf_datapath #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.ENTRY_BITS (ENTRY_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.uw            (uw),
		.cfg           (cfg_q),
		.in_accept     (in_accept),
		.in_cmd        (s_tuser),
		.in_row        (s_tdata[5:0]),
		.in_col        (s_tdata[11:6]),
		.in_value      (s_tdata[35:12]),
		.out_ready     (m_tready),
		.status        (status),
		.out_valid     (m_tvalid),
		.out_value     (out_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.out_height    (out_height),
		.out_width     (out_width),
		.out_last      (out_last),
		.out_exhausted (out_exhausted)
	);

	assign m_tdata = {6'b0, out_width, out_height, out_col, out_row, out_value};
	assign m_tuser = out_exhausted;
	assign m_tlast = out_last;

endmodule

[dv/tb_haar_feature_evaluator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Haar feature evaluator testbench
// Fills a corner of the integral store and writes any other entry just before a
// feature reads it, then runs directed checks of every feature kind, the last
// and exhausted answers and saturating registers, followed by random runs of
// next, write, restart and ignored requests under several register settings.
// Each result is compared with a feature value computed alongside.
// ----------------------------------------------------------------------------
module tb_haar_feature_evaluator;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int IMG_ROWS = haf_pkg::MAX_ROWS_DEF;
	localparam int IMG_COLS = haf_pkg::MAX_COLS_DEF;
	localparam int PRELOAD_DIM = 8;
	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam logic [6:0] FT_NO_FEATURE = 7'd3;
	// Unit slots of the four diagonal rectangles, in sign order.
	localparam int DIAG_ROW [4] = '{0, 0, 1, 1};
	localparam int DIAG_COL [4] = '{0, 1, 1, 0};

	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [6:0]  height;
		logic [6:0]  width;
		logic        last;
		logic        exhausted;
	} feature_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // row, col, value
	logic [1:0]  s_tuser = '0;   // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // feature_value, cell_row, cell_col, cell_height, cell_width
	logic [0:0]  m_tuser;        // exhausted
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [haf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [haf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the block: registers, enumeration state and integral store.
	logic [1:0] sh_ftype = 2'd0;
	logic       sh_axis = 1'b1;
	logic [6:0] sh_max_h = 7'd1;
	logic [6:0] sh_max_w = 7'd1;
	logic [6:0] sh_img_h = 7'd64;
	logic [6:0] sh_img_w = 7'd64;
	int         pos_row = 0, pos_col = 0, span_rows = 1, span_cols = 1;
	bit         enum_done = 1'b0;
	logic [23:0] integral_img [IMG_ROWS][IMG_COLS];
	bit          written [IMG_ROWS][IMG_COLS];

	feature_t pending_features [$];
	int       errors = 0;
	int       shown = 0;
	int       cycles = 0;
	int       src_idle_pct = 0;
	int       sink_idle_pct = 0;
	int       episode_count = 0;

	haar_feature_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function automatic void split_factors(output int fr, output int fc);
		int f;
		fr = 1;
		fc = 1;
		if (sh_ftype == haf_pkg::FT_EDGE || sh_ftype == haf_pkg::FT_LINE) begin
			f = (sh_ftype == haf_pkg::FT_EDGE) ? 2 : 3;
			if (sh_axis == 1'b0) fr = f;
			else fc = f;
		end else if (sh_ftype == haf_pkg::FT_DIAG) begin
			fr = 2;
			fc = 2;
		end
	endfunction

	// Moves (r, c, h, w) forward to the first feature that fits, if any.
	function automatic bit next_fit(inout int r, inout int c, inout int h, inout int w);
		int lim_h, lim_w, cap_h, cap_w, fr, fc;
		lim_h = (sh_img_h == 0) ? 1 : ((sh_img_h > IMG_ROWS) ? IMG_ROWS : int'(sh_img_h));
		lim_w = (sh_img_w == 0) ? 1 : ((sh_img_w > IMG_COLS) ? IMG_COLS : int'(sh_img_w));
		cap_h = (sh_max_h == 0) ? 1 : int'(sh_max_h);
		cap_w = (sh_max_w == 0) ? 1 : int'(sh_max_w);
		if (sh_ftype > haf_pkg::FT_DIAG) return 1'b0;
		split_factors(fr, fc);
		while (1) begin
			if (r >= lim_h) return 1'b0;
			if (c >= lim_w) begin
				r++;
				c = 0;
				h = 1;
				w = 1;
			end else if (h > cap_h || r + fr * h > lim_h) begin
				c++;
				h = 1;
				w = 1;
			end else if (w > cap_w || c + fc * w > lim_w) begin
				h++;
				w = 1;
			end else begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [31:0] feature_sum(int r, int c, int h, int w);
		int fr, fc, n, sr, sc, t0, t1, b0, b1;
		logic [31:0] acc, s;
		split_factors(fr, fc);
		n = (sh_ftype == haf_pkg::FT_EDGE) ? 2 : ((sh_ftype == haf_pkg::FT_LINE) ? 3 : 4);
		acc = '0;
		for (int k = 0; k < n; k++) begin
			sr = (sh_ftype == haf_pkg::FT_DIAG) ? DIAG_ROW[k] : ((fr > 1) ? k : 0);
			sc = (sh_ftype == haf_pkg::FT_DIAG) ? DIAG_COL[k] : ((fc > 1) ? k : 0);
			t0 = r + sr * h;
			t1 = c + sc * w;
			b0 = t0 + h - 1;
			b1 = t1 + w - 1;
			// Border terms outside the image are left out.
			s = 32'(integral_img[b0][b1]);
			if (t0 > 0 && t1 > 0) s = s + 32'(integral_img[t0-1][t1-1]);
			if (t0 > 0) s = s - 32'(integral_img[t0-1][b1]);
			if (t1 > 0) s = s - 32'(integral_img[b0][t1-1]);
			if (k % 2 == 1) acc = acc + s;
			else acc = acc - s;
		end
		return acc;
	endfunction

	function automatic void predict_request(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
			logic [23:0] val);
		feature_t f;
		int r, c, h, w;
		f = '0;
		case (cmd)
			haf_pkg::CMD_WRITE: begin
				integral_img[row][col] = val;
				written[row][col] = 1'b1;
			end
			haf_pkg::CMD_RESTART: begin
				pos_row = 0;
				pos_col = 0;
				span_rows = 1;
				span_cols = 1;
				enum_done = 1'b0;
			end
			haf_pkg::CMD_NEXT: begin
				r = pos_row;
				c = pos_col;
				h = span_rows;
				w = span_cols;
				if (enum_done || !next_fit(r, c, h, w)) begin
					enum_done = 1'b1;
					f.exhausted = 1'b1;
				end else begin
					f.value = feature_sum(r, c, h, w);
					f.row = 6'(r);
					f.col = 6'(c);
					f.height = 7'(h);
					f.width = 7'(w);
					w++;
					if (next_fit(r, c, h, w)) begin
						pos_row = r;
						pos_col = c;
						span_rows = h;
						span_cols = w;
					end else begin
						enum_done = 1'b1;
						f.last = 1'b1;
					end
				end
				pending_features.push_back(f);
			end
			default: ;
		endcase
	endfunction

	function automatic void field_check(string name, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("mismatch %s: expected 0x%08h, got 0x%08h", name, exp_val, got_val);
			end
		end
	endfunction

	always @(posedge clk) begin
		feature_t exp_f;
		feature_t got_f;
		if (arst_n && m_tvalid && m_tready) begin
			got_f.value = m_tdata[31:0];
			got_f.row = m_tdata[37:32];
			got_f.col = m_tdata[43:38];
			got_f.height = m_tdata[50:44];
			got_f.width = m_tdata[57:51];
			got_f.last = m_tlast;
			got_f.exhausted = m_tuser[0];
			if (pending_features.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result: tdata 0x%016h", m_tdata);
				end
			end else begin
				exp_f = pending_features.pop_front();
				field_check("feature_value", exp_f.value, got_f.value);
				field_check("cell_row", 32'(exp_f.row), 32'(got_f.row));
				field_check("cell_col", 32'(exp_f.col), 32'(got_f.col));
				field_check("cell_height", 32'(exp_f.height), 32'(got_f.height));
				field_check("cell_width", 32'(exp_f.width), 32'(got_f.width));
				field_check("last", 32'(exp_f.last), 32'(got_f.last));
				field_check("exhausted", 32'(exp_f.exhausted), 32'(got_f.exhausted));
			end
		end
	end

	// Valid stays high from one request to the next unless a gap is drawn.
	task automatic send_request(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
			logic [23:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, val, col, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_request(cmd, row, col, val);
	endtask

	task automatic write_entry_once(int r, int c);
		if (!written[r][c]) begin
			send_request(haf_pkg::CMD_WRITE, 6'(r), 6'(c), 24'($urandom));
		end
	endtask

	// The coming next request must only read entries that were written before.
	task automatic fill_feature_reads();
		int r, c, h, w, fr, fc, n, sr, sc, t0, t1, b0, b1;
		r = pos_row;
		c = pos_col;
		h = span_rows;
		w = span_cols;
		if (enum_done || !next_fit(r, c, h, w)) return;
		split_factors(fr, fc);
		n = (sh_ftype == haf_pkg::FT_EDGE) ? 2 : ((sh_ftype == haf_pkg::FT_LINE) ? 3 : 4);
		for (int k = 0; k < n; k++) begin
			sr = (sh_ftype == haf_pkg::FT_DIAG) ? DIAG_ROW[k] : ((fr > 1) ? k : 0);
			sc = (sh_ftype == haf_pkg::FT_DIAG) ? DIAG_COL[k] : ((fc > 1) ? k : 0);
			t0 = r + sr * h;
			t1 = c + sc * w;
			b0 = t0 + h - 1;
			b1 = t1 + w - 1;
			write_entry_once(b0, b1);
			if (t0 > 0 && t1 > 0) write_entry_once(t0 - 1, t1 - 1);
			if (t0 > 0) write_entry_once(t0 - 1, b1);
			if (t1 > 0) write_entry_once(b0, t1 - 1);
		end
	endtask

	task automatic send_next();
		fill_feature_reads();
		send_request(haf_pkg::CMD_NEXT, 6'($urandom), 6'($urandom), 24'($urandom));
	endtask

	task automatic send_restart();
		send_request(haf_pkg::CMD_RESTART, 6'($urandom), 6'($urandom), 24'($urandom));
	endtask

	task automatic wait_settled();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_features.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic program_regs(logic [6:0] ftype, logic [6:0] axis, logic [6:0] max_h,
			logic [6:0] max_w, logic [6:0] img_h, logic [6:0] img_w);
		logic [6:0] vals [6];
		haf_pkg::reg_idx_t idx;
		vals = '{ftype, axis, max_h, max_w, img_h, img_w};
		wait_settled();
		for (int i = 0; i < 6; i++) begin
			idx = haf_pkg::reg_idx_t'(i);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (idx)
				haf_pkg::REG_FEATURE_TYPE:    sh_ftype = vals[i][1:0];
				haf_pkg::REG_SPLIT_AXIS:      sh_axis = vals[i][0];
				haf_pkg::REG_MAX_CELL_HEIGHT: sh_max_h = vals[i];
				haf_pkg::REG_MAX_CELL_WIDTH:  sh_max_w = vals[i];
				haf_pkg::REG_IMAGE_HEIGHT:    sh_img_h = vals[i];
				haf_pkg::REG_IMAGE_WIDTH:     sh_img_w = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// The top-left corner is written up front, with both extreme entry values.
	task automatic test_preload();
		logic [23:0] val;
		for (int r = 0; r < PRELOAD_DIM; r++) begin
			for (int c = 0; c < PRELOAD_DIM; c++) begin
				val = 24'($urandom);
				if (r == 0 && c == 0) val = 24'h000000;
				if (r == PRELOAD_DIM - 1 && c == PRELOAD_DIM - 1) val = 24'hFFFFFF;
				send_request(haf_pkg::CMD_WRITE, 6'(r), 6'(c), val);
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_next();
		send_next();
	endtask

	task automatic test_feature_kinds();
		for (int ft = 0; ft < 3; ft++) begin
			for (int ax = 0; ax < 2; ax++) begin
				program_regs(7'(ft), 7'(ax), 7'd2, 7'd2, 7'd5, 7'd6);
				send_restart();
				send_next();
			end
		end
	endtask

	// A one-feature image: the only feature is last, then exhausted until restart.
	task automatic test_last_and_exhausted();
		program_regs(7'(haf_pkg::FT_EDGE), 7'd1, 7'd1, 7'd1, 7'd1, 7'd2);
		send_restart();
		send_next();
		send_next();
		send_next();
		send_request(CMD_IGNORED, 6'h3F, 6'h3F, 24'hFFFFFF);
		send_restart();
		send_next();
	endtask

	task automatic test_degenerate_regs();
		// Zero image height and zero cell maxima count as one; width saturates.
		program_regs(7'(haf_pkg::FT_LINE), 7'd1, 7'd0, 7'd0, 7'd0, 7'd127);
		send_restart();
		send_next();
		send_next();
		program_regs(7'(haf_pkg::FT_DIAG), 7'd0, 7'd0, 7'd0, 7'd0, 7'd127);
		send_restart();
		send_next();
		program_regs(FT_NO_FEATURE, 7'd0, 7'd3, 7'd3, 7'd8, 7'd8);
		send_restart();
		send_next();
	endtask

	task automatic test_large_image();
		program_regs(7'(haf_pkg::FT_DIAG), 7'd1, 7'd64, 7'd64, 7'd127, 7'd64);
		send_restart();
		send_next();
		send_next();
		send_next();
		// Narrowing the cell width mid-run continues from the stored position.
		program_regs(7'(haf_pkg::FT_DIAG), 7'd1, 7'd64, 7'd1, 7'd64, 7'd64);
		send_next();
		send_next();
	endtask

	function automatic logic [6:0] pick_dim(bit wide);
		int sel;
		sel = $urandom_range(15);
		if (wide) begin
			if (sel < 4) return 7'd127;
			if (sel < 8) return 7'd64;
			return 7'($urandom_range(33, 64));
		end
		if (sel == 0) return 7'd0;
		return 7'($urandom_range(1, 7));
	endfunction

	function automatic logic [6:0] pick_cell(bit wide);
		int sel;
		sel = $urandom_range(7);
		if (wide) return (sel == 0) ? 7'd127 : 7'($urandom_range(1, 64));
		if (sel == 0) return 7'd0;
		return 7'($urandom_range(1, 4));
	endfunction

	task automatic send_random_item();
		int sel;
		logic [23:0] val;
		sel = $urandom_range(99);
		if (sel < 68) begin
			send_next();
		end else if (sel < 86) begin
			case ($urandom_range(7))
				0: val = 24'h000000;
				1: val = 24'hFFFFFF;
				default: val = 24'($urandom);
			endcase
			send_request(haf_pkg::CMD_WRITE, 6'($urandom), 6'($urandom), val);
		end else if (sel < 93) begin
			send_restart();
		end else begin
			send_request(CMD_IGNORED, 6'($urandom), 6'($urandom), 24'($urandom));
		end
	endtask

	// Runs of requests, each under a fresh register setting, mostly after a restart.
	task automatic run_random_phase(int target);
		int sent, n;
		bit wide;
		logic [6:0] ftype;
		sent = 0;
		while (sent < target) begin
			episode_count++;
			wide = (episode_count % 8 == 0);
			ftype = ($urandom_range(9) == 0) ? FT_NO_FEATURE : 7'($urandom_range(2));
			program_regs(ftype, 7'($urandom_range(1)), pick_cell(wide), pick_cell(wide),
				pick_dim(wide), pick_dim(wide));
			if ($urandom_range(3) != 0) begin
				send_restart();
				sent++;
			end
			n = wide ? 8 : $urandom_range(15, 40);
			for (int i = 0; i < n; i++) begin
				send_random_item();
				sent++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 22;
		sink_idle_pct = 87;
		test_preload();
		test_reset_defaults();
		test_feature_kinds();
		test_last_and_exhausted();
		test_degenerate_regs();
		test_large_image();
		run_random_phase(180);

		src_idle_pct = 87;
		sink_idle_pct = 22;
		run_random_phase(180);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_random_phase(180);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_features.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0 && pending_features.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/haf_pkg.sv
rtl/haf_sequencer.sv
rtl/haf_datapath.sv
rtl/haar_feature_evaluator.sv
dv/tb_haar_feature_evaluator.sv
